FILE: design/tod_pkg.sv
`default_nettype none

package tod_pkg;

	// item codes
	typedef enum logic [2:0] {
		FUNC_TICK  = 3'd0,
		FUNC_SET   = 3'd1,
		FUNC_READ  = 3'd2,
		FUNC_STOP  = 3'd3,
		FUNC_START = 3'd4
	} func_t;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// tick count held as hours, minutes, five-second units and ticks within them
	// (91 ticks make five seconds)
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [3:0] fives;
		logic [6:0] phase;
	} tod_time_t;

	// one-cycle commands into the time register
	typedef struct packed {
		logic tick;
		logic load;
		logic stop;
		logic start;
	} tod_ctrl_t;

	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINUTE_MAX = 6'd59;
	localparam logic [5:0] SECOND_MAX = 6'd59;
	localparam logic [3:0] FIVES_MAX  = 4'd11;
	localparam logic [6:0] PHASE_MAX  = 7'd90;

	// the count 1572462 in split form: the tick after it goes to midnight
	localparam tod_time_t WRAP_TIME = '{hour: 5'd23, minute: 6'd59, fives: 4'd11, phase: 7'd73};

	// whole seconds past the minute: 5 per five-second unit plus floor(phase*5/91)
	function automatic logic [5:0] seconds_of(input tod_time_t t);
		logic [2:0] frac;
		frac = 3'(t.phase >= 7'd19) + 3'(t.phase >= 7'd37)
			+ 3'(t.phase >= 7'd55) + 3'(t.phase >= 7'd73);
		return {t.fives, 2'b00} + {2'b00, t.fives} + {3'b000, frac};
	endfunction

endpackage

`default_nettype wire

FILE: design/tod_set_decode.sv
`default_nettype none

module tod_set_decode (
	input  wire logic [4:0]         hours,
	input  wire logic [5:0]         minutes,
	input  wire logic [5:0]         seconds,
	output tod_pkg::tod_time_t      load_time,
	output logic                    in_range
);

	logic [9:0] sec_x13;
	logic [3:0] fives;
	logic [5:0] rem_full;
	logic [2:0] rem;

	// seconds / 5 as (s*13) >> 6, exact for 0..59
	assign sec_x13  = {4'b0000, seconds} * 10'd13;
	assign fives    = sec_x13[9:6];
	assign rem_full = seconds - {fives, 2'b00} - {2'b00, fives};
	assign rem      = rem_full[2:0];

	assign in_range = (hours <= tod_pkg::HOUR_MAX) && (minutes <= tod_pkg::MINUTE_MAX)
		&& (seconds <= tod_pkg::SECOND_MAX);

	always_comb begin
		load_time.hour   = hours;
		load_time.minute = minutes;
		load_time.fives  = fives;
		// floor(rem*91/5)
		unique case (rem)
			3'd0: load_time.phase = 7'd0;
			3'd1: load_time.phase = 7'd18;
			3'd2: load_time.phase = 7'd36;
			3'd3: load_time.phase = 7'd54;
			3'd4: load_time.phase = 7'd72;
			default: load_time.phase = 7'd0;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/tod_state.sv
`default_nettype none

module tod_state (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tod_pkg::tod_ctrl_t ctrl,
	input  wire tod_pkg::tod_time_t load_time,
	output tod_pkg::tod_time_t      time_q,
	output logic                    running_q
);

	tod_pkg::tod_time_t next_tick;

	// ripple the split count up by one tick
	always_comb begin
		next_tick = time_q;
		if (time_q == tod_pkg::WRAP_TIME) begin
			next_tick = '0;
		end else if (time_q.phase != tod_pkg::PHASE_MAX) begin
			next_tick.phase = time_q.phase + 7'd1;
		end else begin
			next_tick.phase = '0;
			if (time_q.fives != tod_pkg::FIVES_MAX) begin
				next_tick.fives = time_q.fives + 4'd1;
			end else begin
				next_tick.fives = '0;
				if (time_q.minute != tod_pkg::MINUTE_MAX) begin
					next_tick.minute = time_q.minute + 6'd1;
				end else begin
					next_tick.minute = '0;
					next_tick.hour   = time_q.hour + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			running_q <= 1'b1;
		end else begin
			if (ctrl.load) begin
				time_q <= load_time;
			end else if (ctrl.tick) begin
				time_q <= next_tick;
			end
			if (ctrl.stop) begin
				running_q <= 1'b0;
			end else if (ctrl.start) begin
				running_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/time_of_day_tick_clock.sv
// time-of-day clock counting 18.2 hz timer ticks since midnight
//
// input channel: in_valid / in_stall carry one word of func and the set fields
// output channel: out_valid / out_stall carry one result word per input word
//   (status, out_hours, out_minutes, out_seconds)
// a word is taken at a rising edge with valid high and stall low
//
// a word accepted into the input register stage is processed there, and its
// result is registered in the output register once that register is free
// throughput: one word per cycle while the receiver does not stall, set by the
// single input register to result register pass
//
// reset: count is midnight, ticking enabled, both stages empty
// when the receiver stalls, the result holds; one more word may sit in the
// input stage, after which in_stall rises until the result is taken
`default_nettype none

module time_of_day_tick_clock (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] func,
	input  wire logic [4:0] set_hours,
	input  wire logic [5:0] set_minutes,
	input  wire logic [5:0] set_seconds,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            status,
	output logic [4:0]      out_hours,
	output logic [5:0]      out_minutes,
	output logic [5:0]      out_seconds
);

	// input stage
	logic       valid_s1;
	logic [2:0] func_s1;
	logic [4:0] hours_s1;
	logic [5:0] minutes_s1;
	logic [5:0] seconds_s1;

	// output stage
	logic       out_valid_q;
	logic       status_q;
	logic [4:0] hours_q;
	logic [5:0] minutes_q;
	logic [5:0] seconds_q;

	logic advance;
	logic fire;
	logic in_take;

	tod_pkg::tod_ctrl_t ctrl;
	tod_pkg::tod_time_t load_time;
	tod_pkg::tod_time_t time_q;
	logic               running_q;
	logic               set_ok;

	logic       res_status;
	logic [4:0] res_hours;
	logic [5:0] res_minutes;
	logic [5:0] res_seconds;

	// output register frees up when empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1    <= func;
			hours_s1   <= set_hours;
			minutes_s1 <= set_minutes;
			seconds_s1 <= set_seconds;
		end
	end

	tod_set_decode u_set_decode (
		.hours     (hours_s1),
		.minutes   (minutes_s1),
		.seconds   (seconds_s1),
		.load_time (load_time),
		.in_range  (set_ok)
	);

	// decode the word in the input stage into commands and a result
	always_comb begin
		ctrl        = '0;
		res_status  = tod_pkg::STATUS_OK;
		res_hours   = '0;
		res_minutes = '0;
		res_seconds = '0;
		unique case (tod_pkg::func_t'(func_s1))
			tod_pkg::FUNC_TICK: begin
				ctrl.tick = fire && running_q;
			end
			tod_pkg::FUNC_SET: begin
				// a set loads even while stopped
				if (set_ok) begin
					ctrl.load = fire;
				end else begin
					res_status = tod_pkg::STATUS_REJECT;
				end
			end
			tod_pkg::FUNC_READ: begin
				res_hours   = time_q.hour;
				res_minutes = time_q.minute;
				res_seconds = tod_pkg::seconds_of(time_q);
			end
			tod_pkg::FUNC_STOP: begin
				ctrl.stop = fire;
			end
			tod_pkg::FUNC_START: begin
				ctrl.start = fire;
			end
			default: begin
				// unused codes give an all-zero result
			end
		endcase
	end

	tod_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load_time (load_time),
		.time_q    (time_q),
		.running_q (running_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= res_status;
			hours_q   <= res_hours;
			minutes_q <= res_minutes;
			seconds_q <= res_seconds;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_hours   = hours_q;
	assign out_minutes = minutes_q;
	assign out_seconds = seconds_q;

	// input only backs up behind a stalled result
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// a rejected set carries no time
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (out_hours == 5'd0 && out_minutes == 6'd0
			&& out_seconds == 6'd0))
		else $error("rejected set with nonzero time fields");

	// split count stays within its digit ranges
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (time_q.hour <= tod_pkg::HOUR_MAX && time_q.minute <= tod_pkg::MINUTE_MAX
			&& time_q.fives <= tod_pkg::FIVES_MAX && time_q.phase <= tod_pkg::PHASE_MAX))
		else $error("time register out of range");

	// a processed word always lands in the output register
	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("processed word lost");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tod_pkg::*;

	// run shape
	localparam int RANDOM_WORDS   = 1650;
	localparam int WATCHDOG_LIMIT = 5000;   // cycles with no word moving on either side
	localparam int HOLD_CYCLES    = 400;    // the one long receiver hold-off
	localparam int HOLD_SEGMENT   = 6;      // receiver segment that holds off
	localparam int DRAIN_CYCLES   = 8;      // tail after the last result

	// timekeeping constants
	localparam int unsigned WRAP_COUNT    = 1572462;
	localparam int unsigned TICKS_PER_HR  = 65520;
	localparam int unsigned TICKS_PER_MIN = 1092;
	localparam int unsigned SEC_TICKS_NUM = 91;
	localparam int unsigned SEC_TICKS_DEN = 5;
	localparam int unsigned SECS_PER_HR   = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned TICKS_NUM     = 182;
	localparam int unsigned TICKS_DEN     = 10;

	// codes with no function, the block must answer them plainly
	localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic       status;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} reading_t;

	// clock state copy, predicted readings and their checking
	class tod_tracker;
		logic [20:0] ticks;
		logic        running;
		reading_t    pending_readings[$];
		int          mismatches;

		function new();
			ticks      = '0;
			running    = 1'b1;
			mismatches = 0;
		endfunction

		task report_mismatch(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		// advance the copy for one accepted word and queue what it must produce
		function void predict_word(logic [2:0] f, logic [4:0] hr, logic [5:0] mn,
				logic [5:0] sc);
			reading_t    r;
			int unsigned total;
			int unsigned hh;
			int unsigned mm;
			r = '0;
			case (f)
				FUNC_TICK: begin
					if (running)
						ticks = (32'(ticks) >= WRAP_COUNT) ? '0 : ticks + 21'd1;
				end
				FUNC_SET: begin
					if (hr > HOUR_MAX || mn > MINUTE_MAX || sc > SECOND_MAX)
						r.status = STATUS_REJECT;
					else
						ticks = 21'(32'(hr) * TICKS_PER_HR + 32'(mn) * TICKS_PER_MIN
							+ (32'(sc) * SEC_TICKS_NUM) / SEC_TICKS_DEN);
				end
				FUNC_READ: begin
					total     = (32'(ticks) * TICKS_DEN) / TICKS_NUM;
					hh        = total / SECS_PER_HR;
					total     = total - hh * SECS_PER_HR;
					mm        = total / SECS_PER_MIN;
					r.hours   = 5'(hh);
					r.minutes = 6'(mm);
					r.seconds = 6'(total - mm * SECS_PER_MIN);
				end
				FUNC_STOP:  running = 1'b0;
				FUNC_START: running = 1'b1;
				default: ;
			endcase
			pending_readings.push_back(r);
		endfunction

		task check_reading(reading_t got);
			reading_t want;
			if (pending_readings.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing expected", got));
				return;
			end
			want = pending_readings.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
			if (got.hours !== want.hours)
				report_mismatch($sformatf("hours %0d, expected %0d", got.hours, want.hours));
			if (got.minutes !== want.minutes)
				report_mismatch($sformatf("minutes %0d, expected %0d",
					got.minutes, want.minutes));
			if (got.seconds !== want.seconds)
				report_mismatch($sformatf("seconds %0d, expected %0d",
					got.seconds, want.seconds));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] func;
	logic [4:0] set_hours;
	logic [5:0] set_minutes;
	logic [5:0] set_seconds;
	logic       out_valid;
	logic       out_stall;
	logic       status;
	logic [4:0] out_hours;
	logic [5:0] out_minutes;
	logic [5:0] out_seconds;

	tod_tracker tracker = new();

	// sender burst bookkeeping
	int words_sent;
	int burst_left;
	int idle_cycles;

	time_of_day_tick_clock i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.set_hours   (set_hours),
		.set_minutes (set_minutes),
		.set_seconds (set_seconds),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_hours   (out_hours),
		.out_minutes (out_minutes),
		.out_seconds (out_seconds)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// offer one word from the falling edge and hold it until a rising edge takes it
	task automatic drive_word(logic [2:0] f, logic [4:0] hr, logic [5:0] mn, logic [5:0] sc);
		@(negedge clk);
		in_valid    <= 1'b1;
		func        <= f;
		set_hours   <= hr;
		set_minutes <= mn;
		set_seconds <= sc;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// sender gap: valid low for a number of cycles
	task automatic pause(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// send a word inside the current burst, opening a gap when the burst runs out
	task automatic issue(logic [2:0] f, logic [4:0] hr, logic [5:0] mn, logic [5:0] sc);
		drive_word(f, hr, mn, sc);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// some bursts run straight into the next one
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 20));
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// set fields, mostly legal, now and then anywhere in the port range
	task automatic issue_random_set();
		logic [4:0] hr;
		logic [5:0] mn;
		logic [5:0] sc;
		hr = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
		mn = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
		sc = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
		issue(FUNC_SET, hr, mn, sc);
	endtask

	// one word of noise: any function, random fields
	task automatic issue_random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			issue(FUNC_TICK, 5'($urandom), 6'($urandom), 6'($urandom));
		else if (pick < 60)
			issue(FUNC_READ, 5'($urandom), 6'($urandom), 6'($urandom));
		else if (pick < 75)
			issue_random_set();
		else if (pick < 81)
			issue(FUNC_STOP, 5'($urandom), 6'($urandom), 6'($urandom));
		else if (pick < 91)
			issue(FUNC_START, 5'($urandom), 6'($urandom), 6'($urandom));
		else
			issue(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
				5'($urandom), 6'($urandom), 6'($urandom));
	endtask

	// run from the last seconds of the day toward, and often across, midnight, reading along the way
	task automatic issue_midnight_run();
		int steps;
		issue(FUNC_START, '0, '0, '0);
		issue(FUNC_SET, HOUR_MAX, MINUTE_MAX, 6'($urandom_range(54, 59)));
		steps = $urandom_range(1, 130);
		repeat (steps) begin
			if ($urandom_range(0, 3) == 0)
				issue(FUNC_READ, 5'($urandom), 6'($urandom), 6'($urandom));
			else
				issue(FUNC_TICK, 5'($urandom), 6'($urandom), 6'($urandom));
		end
		issue(FUNC_READ, '0, '0, '0);
	endtask

	// main stimulus
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = FUNC_TICK;
		set_hours   = '0;
		set_minutes = '0;
		set_seconds = '0;
		words_sent  = 0;
		burst_left  = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset state, field extremes, every function, special cases
		issue(FUNC_READ, '0, '0, '0);
		issue(FUNC_TICK, '0, '0, '0);
		issue(FUNC_READ, '1, '1, '1);
		issue(FUNC_SET, '0, '0, '0);
		issue(FUNC_READ, '0, '0, '0);
		issue(FUNC_SET, HOUR_MAX, MINUTE_MAX, SECOND_MAX);   // latest legal set time
		issue(FUNC_READ, '0, '0, '0);
		issue(FUNC_TICK, '0, '0, '0);                        // onto the wrap point
		issue(FUNC_READ, '0, '0, '0);
		issue(FUNC_TICK, '0, '0, '0);                        // wraps to midnight
		issue(FUNC_READ, '0, '0, '0);
		issue(FUNC_SET, 5'd24, '0, '0);                      // each field out of range
		issue(FUNC_SET, '0, 6'd60, '0);
		issue(FUNC_SET, '0, '0, 6'd60);
		issue(FUNC_SET, '1, '1, '1);
		issue(FUNC_READ, '0, '0, '0);
		issue(FUNC_STOP, '0, '0, '0);
		issue(FUNC_TICK, '0, '0, '0);                        // tick while stopped
		issue(FUNC_SET, 5'd12, 6'd30, 6'd45);                // set while stopped
		issue(FUNC_TICK, '0, '0, '0);
		issue(FUNC_READ, '0, '0, '0);
		issue(FUNC_START, '0, '0, '0);
		issue(FUNC_TICK, '0, '0, '0);
		issue(FUNC_READ, '0, '0, '0);
		for (int c = FUNC_SPARE_FIRST; c <= FUNC_SPARE_LAST; c++)
			issue(3'(c), '1, '1, '1);

		// random: mostly midnight runs with random content, the rest noise
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 39) == 0)
				issue_midnight_run();
			else
				issue_random_word();
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then a short tail for anything stray
		while (tracker.pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_readings.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver: segments of free flow, random stalls and a fixed pattern,
	// plus one long hold-off so the block backs up into its input
	initial begin
		int mode;
		int len;
		int segment;
		out_stall = 1'b0;
		segment   = 0;
		@(posedge arst_n);
		forever begin
			segment++;
			if (segment == HOLD_SEGMENT) begin
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				mode = $urandom_range(0, 3);
				len  = $urandom_range(20, 200);
				for (int n = 0; n < len; n++) begin
					@(negedge clk);
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= 1'($urandom_range(0, 1));
						2: out_stall <= ($urandom_range(0, 3) == 0);
						default: out_stall <= (n % 3 == 0);
					endcase
				end
			end
		end
	end

	// both handshakes sampled at the rising edge: accepted input words feed the
	// prediction, accepted result words are checked against it
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.predict_word(func, set_hours, set_minutes, set_seconds);
			if (out_valid && !out_stall)
				tracker.check_reading('{status, out_hours, out_minutes, out_seconds});
		end
	end

	// watchdog on cycles where no word moves on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

`default_nettype wire
